[rtl/core/aftm_pkg.sv]
package aftm_pkg;

    localparam int TIME_BITS    = 48;
    localparam int SAMPLE_BITS  = 12;
    localparam int CHANNELS_DEF = 2;
    localparam int NULL_BIT_POS = 5;
    localparam int ADDR_BITS    = 3;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_FLOOR_CH0 = 1'b0,
        REG_FLOOR_CH1 = 1'b1
    } t_reg_idx;

    typedef logic [TIME_BITS-1:0]   t_time;
    typedef logic [SAMPLE_BITS-1:0] t_sample;

    // run-time entry: mark valid, mark, run time
    typedef struct packed {
        logic  mark_vld;
        t_time mark;
        t_time run;
    } t_run_ent;

    function automatic t_time sat_add(input t_time a, input t_time b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

    function automatic t_sample sample_lsb_first(input logic [7:0] b1, input logic [7:0] b2,
                                                 input logic [7:0] b3);
        t_sample v;
        v[0] = b1[1];
        v[1] = b1[0];
        for (int i = 2; i < 10; i++) begin
            v[i] = b2[9-i];
        end
        v[10] = b3[7];
        v[11] = b3[6];
        return v;
    endfunction

endpackage

[rtl/core/adc_frame_decode_on_time_meter.sv]
// On-time meter for a two-channel SPI ADC. Each request on the input stream carries one
// four-byte ADC frame, its channel and a millisecond timestamp (or a command that clears the
// unreported totals of all channels); each request yields exactly one result with the decoded
// samples, an error flag for a set null bit, and the channel's run time and unreported total.
// A sample above the channel floor adds the time since the previous on sample (1 ms for the
// first one) to both totals, saturating at 2^48-1; a sample at or below the floor clears the
// run time. Per-channel state sits in two small memories with a registered read; an item
// is read when accepted and updated and written back as it leaves stage 1, with forwarding
// between consecutive items on the same channel. Throughput is one request per clock while
// the result side does not stall; a request passes stage 1 and the result register before
// its result is valid. Floors must be written over the APB port (floor_ch0 at 0x0, floor_ch1
// at 0x4) only while the stream is idle; the block itself does not enforce this.
module adc_frame_decode_on_time_meter #(
    parameter int CHANNELS = aftm_pkg::CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aftm_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // frame_byte0, frame_byte1, frame_byte2, frame_byte3, now_ms[47:0]
    input  logic [79:0]                    s_axis_tdata,
    // cmd, channel
    input  logic [1:0]                     s_axis_tuser,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // sample_msb[11:0], sample_lsb[11:0], is_on, run_time_ms[47:0], unreported_ms[47:0], pad
    output logic [127:0]                   m_axis_tdata,
    // out_channel, frame_error
    output logic [1:0]                     m_axis_tuser
);
    import aftm_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration
    t_sample r_floor [2];

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor[0] <= '0;
            r_floor[1] <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_FLOOR_CH1) begin
                r_floor[1] <= pwdata[SAMPLE_BITS-1:0];
            end else begin
                r_floor[0] <= pwdata[SAMPLE_BITS-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_FLOOR_CH1) ? {20'b0, r_floor[1]} : {20'b0, r_floor[0]};

    // input unpack
    logic        in_acc;
    logic        in_cmd;
    logic        in_ch;
    logic [CH_W-1:0] in_addr;

    assign in_cmd  = s_axis_tuser[0];
    assign in_ch   = s_axis_tuser[1];
    assign in_addr = CH_W'(in_ch);

    // state memories
    t_run_ent mem_run [CHANNELS];
    t_time    mem_unr [CHANNELS];
    logic [CHANNELS-1:0] r_run_vld;
    logic [CHANNELS-1:0] r_unr_vld;

    // stage 1
    logic        r_s1_vld;
    logic        r_s1_cmd;
    logic        r_s1_ch;
    logic [31:0] r_s1_frame;
    t_time       r_s1_now;
    t_run_ent    r_rd_run;
    t_time       r_rd_unr;
    logic        r_fwd_hit;
    t_run_ent    r_fwd_run;
    t_time       r_fwd_unr;

    logic        s1_adv;
    logic        wr_en;
    logic [CH_W-1:0] s1_addr;
    t_run_ent    cur_run;
    t_time       cur_unr;
    t_run_ent    new_run;
    t_time       new_unr;
    logic        ch_ok;
    logic [7:0]  b0, b1, b2, b3;
    t_sample     smsb, slsb, flr;
    logic        on;
    t_time       dur;

    // result
    logic        r_o_vld;
    logic        r_o_ch;
    logic        r_o_err;
    t_sample     r_o_smsb;
    t_sample     r_o_slsb;
    logic        r_o_on;
    t_time       r_o_run;
    t_time       r_o_unr;
    logic        n_o_err;
    t_sample     n_o_smsb;
    t_sample     n_o_slsb;
    logic        n_o_on;
    t_time       n_o_run;
    t_time       n_o_unr;

    assign s1_adv        = !r_o_vld || m_axis_tready;
    assign s_axis_tready = !r_s1_vld || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s1_addr       = CH_W'(r_s1_ch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd   <= in_cmd;
            r_s1_ch    <= in_ch;
            r_s1_frame <= s_axis_tdata[31:0];
            r_s1_now   <= s_axis_tdata[79:32];
            r_rd_run   <= mem_run[in_addr];
            r_rd_unr   <= mem_unr[in_addr];
            r_fwd_hit  <= wr_en && (r_s1_ch == in_ch);
            r_fwd_run  <= new_run;
            r_fwd_unr  <= new_unr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_run[s1_addr] <= new_run;
            mem_unr[s1_addr] <= new_unr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_vld <= '0;
            r_unr_vld <= '0;
        end else if (r_s1_vld && s1_adv) begin
            if (r_s1_cmd == CMD_CLEAR) begin
                r_unr_vld <= '0;
            end else if (wr_en) begin
                r_run_vld[s1_addr] <= 1'b1;
                r_unr_vld[s1_addr] <= 1'b1;
            end
        end
    end

    always_comb begin
        ch_ok = (32'(r_s1_ch) < CHANNELS);
        b0    = r_s1_frame[7:0];
        b1    = r_s1_frame[15:8];
        b2    = r_s1_frame[23:16];
        b3    = r_s1_frame[31:24];
        smsb  = {b0[4:0], b1[7:1]};
        slsb  = sample_lsb_first(b1, b2, b3);
        flr   = r_floor[r_s1_ch];
        on    = (smsb > flr);

        if (r_fwd_hit) begin
            cur_run = r_fwd_run;
        end else if (!r_run_vld[s1_addr]) begin
            cur_run = '0;
        end else begin
            cur_run = r_rd_run;
        end
        if (r_fwd_hit) begin
            cur_unr = r_fwd_unr;
        end else if (!r_unr_vld[s1_addr]) begin
            cur_unr = '0;
        end else begin
            cur_unr = r_rd_unr;
        end

        if (!cur_run.mark_vld) begin
            dur = TIME_BITS'(1);
        end else if (r_s1_now >= cur_run.mark) begin
            dur = r_s1_now - cur_run.mark;
        end else begin
            dur = '0;
        end

        if (on) begin
            new_run.mark_vld = 1'b1;
            new_run.mark     = r_s1_now;
            new_run.run      = sat_add(cur_run.run, dur);
            new_unr          = sat_add(cur_unr, dur);
        end else begin
            new_run = '0;
            new_unr = cur_unr;
        end

        wr_en = r_s1_vld && s1_adv && (r_s1_cmd == CMD_SAMPLE) && ch_ok
                && !b0[NULL_BIT_POS];

        n_o_err  = 1'b0;
        n_o_smsb = '0;
        n_o_slsb = '0;
        n_o_on   = 1'b0;
        n_o_run  = '0;
        n_o_unr  = '0;
        if (r_s1_cmd == CMD_CLEAR) begin
            if (ch_ok) begin
                n_o_run = cur_run.run;
            end
        end else if (!ch_ok) begin
            n_o_err = 1'b1;
        end else if (b0[NULL_BIT_POS]) begin
            n_o_err = 1'b1;
            n_o_run = cur_run.run;
            n_o_unr = cur_unr;
        end else begin
            n_o_smsb = smsb;
            n_o_slsb = slsb;
            n_o_on   = on;
            n_o_run  = new_run.run;
            n_o_unr  = new_unr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_adv) begin
            r_o_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && s1_adv) begin
            r_o_ch   <= r_s1_ch;
            r_o_err  <= n_o_err;
            r_o_smsb <= n_o_smsb;
            r_o_slsb <= n_o_slsb;
            r_o_on   <= n_o_on;
            r_o_run  <= n_o_run;
            r_o_unr  <= n_o_unr;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tuser  = {r_o_err, r_o_ch};
    assign m_axis_tdata  = {7'b0, r_o_unr, r_o_run, r_o_on, r_o_slsb, r_o_smsb};

endmodule

[tb/adc_frame_decode_on_time_meter_tb.sv]
`timescale 1ns / 100ps

module adc_frame_decode_on_time_meter_tb;

    import aftm_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DIR_ROWS    = 21;
    localparam int SEG_ITEMS   = 272;

    typedef struct {
        t_cmd       cmd;
        logic       ch;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        t_time      now;
    } meter_req_t;

    typedef struct {
        logic    ch;
        logic    err;
        t_sample smsb;
        t_sample slsb;
        logic    on;
        t_time   run;
        t_time   unrep;
    } meter_res_t;

    typedef struct {
        t_cmd       cmd;
        logic       ch;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        t_time      now;
        bit         typed;
        logic       err;
        t_sample    smsb;
        t_sample    slsb;
        logic       on;
        t_time      run;
        t_time      unrep;
    } dir_row_t;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // frame_byte0, frame_byte1, frame_byte2, frame_byte3, now_ms[47:0]
    logic [79:0] s_axis_tdata  = '0;
    // cmd, channel
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // sample_msb, sample_lsb, is_on, run_time_ms, unreported_ms, pad
    logic [127:0] m_axis_tdata;
    // out_channel, frame_error
    logic [1:0]  m_axis_tuser;

    t_sample    floor_lvl [2] = '{default: '0};
    t_time      run_ms    [2] = '{default: '0};
    t_time      mark_ms   [2] = '{default: '0};
    logic       mark_set  [2] = '{default: 1'b0};
    t_time      unrep_ms  [2] = '{default: '0};
    t_time      time_base [2] = '{default: '0};
    meter_res_t due_results [$];

    int send_idle_pct = 20;
    int recv_idle_pct = 53;
    int err_count     = 0;
    int stall_cnt     = 0;
    int n_req         = 0;
    int n_clear       = 0;
    int n_null        = 0;
    int n_on          = 0;
    int n_res         = 0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{CMD_SAMPLE, 0, 'h00, 'h00, 'h00, 'h00, 100, 1, 0, 'h000, 'h000, 0, 0, 0},
        '{CMD_SAMPLE, 0, 'h1F, 'hFE, 'hFF, 'hC0, 0, 1, 0, 'hFFF, 'hFFD, 1, 1, 1},
        '{CMD_SAMPLE, 0, 'h1F, 'hFE, 'hFF, 'hC0, 0, 1, 0, 'hFFF, 'hFFD, 1, 1, 1},
        '{CMD_SAMPLE, 0, 'h1F, 'hFE, 'hFF, 'hC0, 50, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 0, 'h1F, 'hFE, 'hFF, 'hC0, 10, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 0, 'h3F, 'hFF, 'hFF, 'hFF, 60, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 1, 'h20, 'h00, 'h00, 'h00, 5, 1, 1, 'h000, 'h000, 0, 0, 0},
        '{CMD_CLEAR, 0, 'hFF, 'hFF, 'hFF, 'hFF, TIME_MAX, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_CLEAR, 1, 'h00, 'h00, 'h00, 'h00, 0, 1, 0, 'h000, 'h000, 0, 0, 0},
        '{CMD_SAMPLE, 0, 'h1F, 'hFE, 'hFF, 'hC0, TIME_MAX, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 0, 'h1F, 'hFE, 'hFF, 'hC0, TIME_MAX, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 0, 'h1F, 'hFE, 'hFF, 'hC0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 0, 'h1F, 'hFE, 'hFF, 'hC0, TIME_MAX, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 0, 'h00, 'h01, 'h00, 'h00, 7, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 0, 'h00, 'h02, 'h00, 'h00, 9, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 1, 'h15, 'h55, 'hAA, 'h80, 48'h5555_5555_5555, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 1, 'h0A, 'hAA, 'h55, 'h40, 48'hAAAA_AAAA_AAAA, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 1, 'hDF, 'h01, 'h01, 'h00, 48'hAAAA_AAAA_AAAB, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_CLEAR, 0, 'h5A, 'hA5, 'h3C, 'hC3, 48'h0000_0000_1234, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 0, 'h1F, 'hFE, 'hFF, 'hC0, 20, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SAMPLE, 1, 'hC0, 'h00, 'h80, 'hC0, 48'hAAAA_AAAA_AAAC, 0, 0, 0, 0, 0, 0, 0}
    };

    adc_frame_decode_on_time_meter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_time clip_add(input t_time a, input t_time b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

    task automatic meter_step(input meter_req_t r, output meter_res_t e);
        t_time dur;
        e.ch    = r.ch;
        e.err   = 1'b0;
        e.smsb  = '0;
        e.slsb  = '0;
        e.on    = 1'b0;
        e.run   = '0;
        e.unrep = '0;
        if (r.cmd == CMD_CLEAR) begin
            unrep_ms[0] = '0;
            unrep_ms[1] = '0;
            e.run = run_ms[r.ch];
        end else if (r.b0[NULL_BIT_POS]) begin
            e.err   = 1'b1;
            e.run   = run_ms[r.ch];
            e.unrep = unrep_ms[r.ch];
        end else begin
            e.smsb = {r.b0[4:0], r.b1[7:1]};
            e.slsb = {r.b3[6], r.b3[7], r.b2[0], r.b2[1], r.b2[2], r.b2[3],
                      r.b2[4], r.b2[5], r.b2[6], r.b2[7], r.b1[0], r.b1[1]};
            if (e.smsb <= floor_lvl[r.ch]) begin
                run_ms[r.ch]   = '0;
                mark_set[r.ch] = 1'b0;
            end else begin
                if (!mark_set[r.ch]) begin
                    dur = 1;
                end else if (r.now >= mark_ms[r.ch]) begin
                    dur = r.now - mark_ms[r.ch];
                end else begin
                    dur = '0;
                end
                run_ms[r.ch]   = clip_add(run_ms[r.ch], dur);
                unrep_ms[r.ch] = clip_add(unrep_ms[r.ch], dur);
                mark_ms[r.ch]  = r.now;
                mark_set[r.ch] = 1'b1;
                e.on = 1'b1;
            end
            e.run   = run_ms[r.ch];
            e.unrep = unrep_ms[r.ch];
        end
    endtask

    task automatic cmp_field(input string name, input logic [47:0] want, input logic [47:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            err_count++;
        end
    endtask

    task automatic send_item(input meter_req_t r, input bit typed, input meter_res_t want);
        meter_res_t calc;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.now, r.b3, r.b2, r.b1, r.b0};
        s_axis_tuser  <= {r.ch, r.cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        meter_step(r, calc);
        due_results.push_back(typed ? want : calc);
        n_req++;
        if (r.cmd == CMD_CLEAR) begin
            n_clear++;
        end else if (r.b0[NULL_BIT_POS]) begin
            n_null++;
        end else if (calc.on) begin
            n_on++;
        end
    endtask

    // hold the request side low until every result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_floor(input t_reg_idx idx, input t_sample lvl);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {20'($urandom), lvl};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        floor_lvl[idx] = lvl;
    endtask

    task automatic run_segment(input int n_items);
        meter_req_t  r;
        meter_res_t  unused;
        t_sample     smp;
        logic [31:0] rnd;
        int          pick;
        int          flr;
        for (int k = 0; k < n_items; k++) begin
            r.ch  = 1'($urandom_range(1));
            r.cmd = ($urandom_range(99) < 3) ? CMD_CLEAR : CMD_SAMPLE;
            flr   = floor_lvl[r.ch];
            pick  = $urandom_range(99);
            if (pick < 55) begin
                smp = (flr < 4095) ? 12'(flr + 1 + $urandom_range(4094 - flr))
                                   : 12'($urandom_range(4095));
            end else if (pick < 75) begin
                smp = 12'($urandom_range(4095));
            end else if (pick < 85) begin
                smp = 12'(flr);
            end else if (pick < 90) begin
                smp = '0;
            end else if (pick < 95) begin
                smp = '1;
            end else begin
                smp = 12'(flr + 1);
            end
            rnd  = $urandom;
            r.b0 = {rnd[7:6], ($urandom_range(99) < 8), smp[11:7]};
            r.b1 = {smp[6:0], rnd[8]};
            r.b2 = rnd[23:16];
            r.b3 = rnd[31:24];
            if (r.cmd == CMD_CLEAR) begin
                rnd  = $urandom;
                r.b0 = rnd[7:0];
                r.b1 = rnd[15:8];
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                r.now = time_base[r.ch] + t_time'($urandom_range(3000));
            end else if (pick < 80) begin
                r.now = {16'($urandom), 32'($urandom)};
            end else if (pick < 88) begin
                r.now = time_base[r.ch] - t_time'($urandom_range(500));
            end else if (pick < 94) begin
                r.now = TIME_MAX - t_time'($urandom_range(3));
            end else begin
                r.now = t_time'($urandom_range(3));
            end
            time_base[r.ch] = r.now;
            send_item(r, 1'b0, unused);
            if ($urandom_range(199) == 0) begin
                drain();
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        meter_res_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            n_res++;
            if (due_results.size() == 0) begin
                $error("result with no request pending");
                err_count++;
            end else begin
                want = due_results.pop_front();
                cmp_field("out_channel", 48'(want.ch), 48'(m_axis_tuser[0]));
                cmp_field("frame_error", 48'(want.err), 48'(m_axis_tuser[1]));
                cmp_field("sample_msb", 48'(want.smsb), 48'(m_axis_tdata[11:0]));
                cmp_field("sample_lsb", 48'(want.slsb), 48'(m_axis_tdata[23:12]));
                cmp_field("is_on", 48'(want.on), 48'(m_axis_tdata[24]));
                cmp_field("run_time_ms", want.run, m_axis_tdata[72:25]);
                cmp_field("unreported_ms", want.unrep, m_axis_tdata[120:73]);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        meter_req_t r;
        meter_res_t want;
        t_sample    f0;
        t_sample    f1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            r.cmd      = dir_tab[i].cmd;
            r.ch       = dir_tab[i].ch;
            r.b0       = dir_tab[i].b0;
            r.b1       = dir_tab[i].b1;
            r.b2       = dir_tab[i].b2;
            r.b3       = dir_tab[i].b3;
            r.now      = dir_tab[i].now;
            want.ch    = dir_tab[i].ch;
            want.err   = dir_tab[i].err;
            want.smsb  = dir_tab[i].smsb;
            want.slsb  = dir_tab[i].slsb;
            want.on    = dir_tab[i].on;
            want.run   = dir_tab[i].run;
            want.unrep = dir_tab[i].unrep;
            send_item(r, dir_tab[i].typed, want);
        end

        for (int seg = 0; seg < 6; seg++) begin
            drain();
            send_idle_pct = (seg < 2) ? 20 : (seg < 4) ? 53 : 0;
            recv_idle_pct = (seg < 2) ? 53 : (seg < 4) ? 20 : 0;
            case (seg)
                0: begin
                    f0 = '1;
                    f1 = '0;
                end
                1: begin
                    f0 = '0;
                    f1 = '1;
                end
                3: begin
                    f0 = 12'h800;
                    f1 = 12'h7FF;
                end
                default: begin
                    f0 = 12'($urandom_range(4095));
                    f1 = 12'($urandom_range(4095));
                end
            endcase
            write_floor(REG_FLOOR_CH0, f0);
            write_floor(REG_FLOOR_CH1, f1);
            run_segment(SEG_ITEMS);
        end
        drain();

        $display("Sent %0d requests: %0d clears, %0d null frames, %0d on samples.",
                 n_req, n_clear, n_null, n_on);
        $display("Checked %0d results over six floor settings and three idle patterns.", n_res);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
